// ===== rtl/tsi_pkg.sv =====
package tsi_pkg;

  // Field and datapath widths
  localparam int unsigned ROOT_W   = 64;
  localparam int unsigned SQ_LO_W  = 64;
  localparam int unsigned SQ_HI_W  = 3;
  localparam int unsigned SQ_W     = SQ_LO_W + SQ_HI_W;
  localparam int unsigned WIDE_W   = 2 * ROOT_W;
  localparam int unsigned HALF_W   = ROOT_W / 2;

  // Truncation shift of the square and reset value of the bound register
  localparam int unsigned SQUARE_SHIFT = 61;
  localparam logic [ROOT_W-1:0] BOUND_RESET = 64'hb504_f333_f9de_6800;

  // Status from the square root unit back to the sequencer
  typedef struct packed {
    logic done;   // one-cycle pulse: root is ready
    logic exact;  // remainder is zero, root*root equals the radicand
  } tsi_sqrt_status_t;

endpackage

// ===== rtl/truncated_square_inverter_unit.sv =====
// Truncated square inverter: for a 67-bit truncated square S it returns the
// unique 64-bit root x with floor(x*x / 2^61) == S, when that root exists and
// is not below root_lower_bound; otherwise found is 0 and root is 0. For
// each request one shared restoring square root unit, bringing down two
// radicand bits per step, finds the ceiling root of S<<61 and then the floor
// root of ((S+1)<<61)-1; a 32x32 multiplier then builds the final square
// check from lo*lo, lo*hi and hi*hi. A new request is taken once the
// previous one has moved into the output register; the bound register may be
// written at any time the block is idle.
module truncated_square_inverter_unit (
  input  logic                        clk,
  input  logic                        rst,
  // configuration write
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [tsi_pkg::ROOT_W-1:0]  cfg_data,
  // input request
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [tsi_pkg::SQ_LO_W-1:0] square_low,
  input  logic [tsi_pkg::SQ_HI_W-1:0] square_high,
  // result
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        found,
  output logic [tsi_pkg::ROOT_W-1:0]  root
);
  import tsi_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOW,
    S_UP,
    S_MUL,
    S_DONE
  } state_t;

  state_t              state;
  logic [ROOT_W-1:0]   root_lower_bound;
  logic [SQ_LO_W-1:0]  sl;
  logic [SQ_HI_W-1:0]  sh;
  logic [ROOT_W-1:0]   lower;
  logic                match;
  logic [1:0]          mcnt;
  logic [2*HALF_W-1:0] prod;
  logic [WIDE_W-1:0]   acc;

  tsi_sqrt_status_t    sq_status;
  logic [ROOT_W-1:0]   sq_root;
  logic                sq_start;
  logic [WIDE_W-1:0]   sq_radicand;

  // Radicands: S<<61 from the ports, ((S+1)<<61)-1 from the captured request
  logic [SQ_W-1:0]     s_plus;
  logic [WIDE_W-1:0]   lsq;
  logic [WIDE_W-1:0]   usq;

  always_comb begin
    s_plus      = {sh, sl} + SQ_W'(1);
    lsq         = {square_high, square_low, {SQUARE_SHIFT{1'b0}}};
    usq         = {s_plus, {SQUARE_SHIFT{1'b0}}} - WIDE_W'(1);
    sq_start    = ((state == S_IDLE) && in_valid) || ((state == S_LOW) && sq_status.done);
    sq_radicand = (state == S_IDLE) ? lsq : usq;
  end

  tsi_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand (sq_radicand),
    .status   (sq_status),
    .root     (sq_root)
  );

  // Square check multiplier: lo*lo, lo*hi (doubled), hi*hi
  logic [HALF_W-1:0]   mul_a;
  logic [HALF_W-1:0]   mul_b;
  logic [WIDE_W-1:0]   prod_sh;

  always_comb begin
    mul_a = lower[HALF_W-1:0];
    mul_b = lower[HALF_W-1:0];
    case (mcnt)
      2'd1: mul_b = lower[ROOT_W-1:HALF_W];
      2'd2: begin
        mul_a = lower[ROOT_W-1:HALF_W];
        mul_b = lower[ROOT_W-1:HALF_W];
      end
      default: ;
    endcase
    // prod holds the product issued in the previous cycle (mcnt - 1)
    case (mcnt)
      2'd1:    prod_sh = {{(WIDE_W - 2*HALF_W){1'b0}}, prod};
      2'd2:    prod_sh = {{(WIDE_W - 2*HALF_W){1'b0}}, prod} << (HALF_W + 1);
      2'd3:    prod_sh = {{(WIDE_W - 2*HALF_W){1'b0}}, prod} << (2 * HALF_W);
      default: prod_sh = '0;
    endcase
  end

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);

  // Bound register
  always_ff @(posedge clk) begin
    if (rst) begin
      root_lower_bound <= BOUND_RESET;
    end else if (cfg_valid) begin
      root_lower_bound <= cfg_data;
    end
  end

  // Sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      mcnt      <= '0;
    end else begin
      // S_DONE reloads the result register itself
      if (out_valid && out_ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            sl    <= square_low;
            sh    <= square_high;
            state <= S_LOW;
          end
        end
        S_LOW: begin
          if (sq_status.done) begin
            // ceiling root, wrapping modulo 2^64
            lower <= sq_root + {{(ROOT_W-1){1'b0}}, ~sq_status.exact};
            state <= S_UP;
          end
        end
        S_UP: begin
          if (sq_status.done) begin
            match <= (lower == sq_root) && (lower >= root_lower_bound);
            acc   <= '0;
            mcnt  <= '0;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          prod <= mul_a * mul_b;
          acc  <= acc + prod_sh;
          mcnt <= mcnt + 1'b1;
          if (mcnt == 2'd3) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            found     <= match && (acc[WIDE_W-1:SQUARE_SHIFT] == {sh, sl});
            root      <= (match && (acc[WIDE_W-1:SQUARE_SHIFT] == {sh, sl})) ? lower : '0;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/tsi_sqrt.sv =====
module tsi_sqrt (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [tsi_pkg::WIDE_W-1:0] radicand,
  output tsi_pkg::tsi_sqrt_status_t status,
  output logic [tsi_pkg::ROOT_W-1:0] root
);
  import tsi_pkg::*;

  localparam int unsigned REM_W = ROOT_W + 2;
  localparam int unsigned CNT_W = $clog2(ROOT_W);

  logic [WIDE_W-1:0] rad;
  logic [REM_W-1:0]  rem;
  logic [CNT_W-1:0]  cnt;
  logic              busy;
  logic              done;

  // One restoring step: bring down two radicand bits, try to subtract 4*root+1
  logic [REM_W:0]    rem_sh;
  logic [REM_W:0]    trial;
  logic [REM_W+1:0]  diff;
  logic              fits;

  always_comb begin
    rem_sh = {rem[REM_W-2:0], rad[WIDE_W-1 -: 2]};
    trial  = {1'b0, root, 2'b01};
    diff   = {1'b0, rem_sh} - {1'b0, trial};
    fits   = ~diff[REM_W+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      if (start) begin
        busy <= 1'b1;
        done <= 1'b0;
        cnt  <= '0;
        rad  <= radicand;
        rem  <= '0;
        root <= '0;
      end else if (busy) begin
        rad  <= {rad[WIDE_W-3:0], 2'b00};
        rem  <= fits ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];
        root <= {root[ROOT_W-2:0], fits};
        cnt  <= cnt + 1'b1;
        // last step raises a one-cycle done
        done <= (cnt == CNT_W'(ROOT_W - 1));
        if (cnt == CNT_W'(ROOT_W - 1)) begin
          busy <= 1'b0;
        end
      end else begin
        done <= 1'b0;
      end
    end
  end

  assign status.done  = done;
  assign status.exact = (rem == '0);

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import tsi_pkg::*;

  typedef struct packed {
    logic [SQ_HI_W-1:0] high;
    logic [SQ_LO_W-1:0] low;
  } square_t;

  typedef struct packed {
    logic              found;
    logic [ROOT_W-1:0] root;
  } root_result_t;

  localparam int unsigned STALL_PCT    = 10;
  localparam int unsigned HOLD_CYCLES  = 800;
  localparam int unsigned HOLD_AT      = 40;
  localparam int unsigned CALM_FIRST   = 300;
  localparam int unsigned CALM_LAST    = 420;
  localparam int unsigned WATCHDOG_MAX = 4000;
  localparam int unsigned DRAIN_CYCLES = 300;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [ROOT_W-1:0]   cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [SQ_LO_W-1:0]  square_low = '0;
  logic [SQ_HI_W-1:0]  square_high = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic                found;
  logic [ROOT_W-1:0]   root;

  // squares waiting to be offered, and roots still owed by the block
  square_t             pending_squares[$];
  root_result_t        expected_roots[$];
  square_t             next_square;
  square_t             taken_square;
  root_result_t        owed;

  logic [ROOT_W-1:0]   cur_bound = BOUND_RESET;
  int unsigned         errors = 0;
  int unsigned         requests_taken = 0;
  int unsigned         results_seen = 0;
  int unsigned         roots_found = 0;
  int unsigned         bound_writes = 0;
  int unsigned         hold_left = 0;
  logic                held_off = 1'b0;
  int unsigned         idle_cycles = 0;

  truncated_square_inverter_unit u_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .square_low (square_low),
    .square_high(square_high),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .found      (found),
    .root       (root)
  );

  always #5 clk = ~clk;

  function automatic logic [ROOT_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // floor of the square root of a 128-bit value, one bit per step
  function automatic logic [ROOT_W-1:0] isqrt_floor(input logic [WIDE_W-1:0] v);
    logic [ROOT_W-1:0] r;
    logic [ROOT_W-1:0] cand;
    logic [WIDE_W-1:0] cw;
    r = '0;
    for (int b = ROOT_W - 1; b >= 0; b--) begin
      cand = r | (64'd1 << b);
      cw = {64'd0, cand};
      if (cw * cw <= v) r = cand;
    end
    return r;
  endfunction

  // truncated square of a root: top 67 bits of x*x
  function automatic square_t truncate_square(input logic [ROOT_W-1:0] x);
    logic [WIDE_W-1:0] xw;
    logic [WIDE_W-1:0] prod;
    square_t s;
    xw = {64'd0, x};
    prod = xw * xw;
    {s.high, s.low} = prod[WIDE_W-1:SQUARE_SHIFT];
    return s;
  endfunction

  // root search: ceiling root of S<<61 against floor root of ((S+1)<<61)-1
  function automatic root_result_t invert_truncated_square(input square_t s,
                                                           input logic [ROOT_W-1:0] lo_bound);
    logic [SQ_W-1:0]   sq;
    logic [WIDE_W-1:0] ceil_target;
    logic [WIDE_W-1:0] floor_target;
    logic [WIDE_W-1:0] cw;
    logic [WIDE_W-1:0] prod;
    logic [ROOT_W-1:0] ceil_root;
    logic [ROOT_W-1:0] floor_root;
    root_result_t      r;
    sq = {s.high, s.low};
    ceil_target = {61'd0, sq} << SQUARE_SHIFT;
    // wraps to all ones at the top of the range
    floor_target = (({61'd0, sq} + 128'd1) << SQUARE_SHIFT) - 128'd1;
    ceil_root = isqrt_floor(ceil_target);
    cw = {64'd0, ceil_root};
    prod = cw * cw;
    // increment wraps to zero when the floor root is all ones
    if (prod < ceil_target) ceil_root = ceil_root + 64'd1;
    floor_root = isqrt_floor(floor_target);
    r = '0;
    if (ceil_root == floor_root && ceil_root >= lo_bound) begin
      cw = {64'd0, ceil_root};
      prod = cw * cw;
      if (prod[WIDE_W-1:SQUARE_SHIFT] == sq) begin
        r.found = 1'b1;
        r.root = ceil_root;
      end
    end
    return r;
  endfunction

  task automatic queue_square(input logic [SQ_HI_W-1:0] h, input logic [SQ_LO_W-1:0] l);
    square_t s;
    s.high = h;
    s.low = l;
    pending_squares.push_back(s);
  endtask

  task automatic queue_root(input logic [ROOT_W-1:0] x);
    pending_squares.push_back(truncate_square(x));
  endtask

  // mostly squares of real roots, near and away from the bound, plus noise
  task automatic queue_random(input int unsigned n);
    int unsigned       k;
    logic [ROOT_W-1:0] x;
    square_t           s;
    for (int unsigned i = 0; i < n; i++) begin
      k = $urandom_range(0, 99);
      if (k < 30) begin
        queue_root(rand64());
      end else if (k < 50) begin
        x = cur_bound + 64'($urandom_range(0, 64)) - 64'd32;
        queue_root(x);
      end else if (k < 60) begin
        queue_root(rand64() >> $urandom_range(1, 63));
      end else if (k < 70) begin
        // neighbor of a real square
        s = truncate_square(rand64());
        if ($urandom_range(0, 1) != 0) {s.high, s.low} = {s.high, s.low} + 67'd1;
        else {s.high, s.low} = {s.high, s.low} - 67'd1;
        pending_squares.push_back(s);
      end else if (k < 95) begin
        queue_square(3'($urandom_range(0, 7)), rand64());
      end else begin
        queue_square(3'($urandom_range(0, 7)),
                     ($urandom_range(0, 1) != 0) ? {SQ_LO_W{1'b1}} : '0);
      end
    end
  endtask

  // block is idle once nothing is queued, offered or owed
  task automatic wait_drained();
    while (pending_squares.size() != 0 || expected_roots.size() != 0 || in_valid)
      @(posedge clk);
  endtask

  task automatic write_bound(input logic [ROOT_W-1:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cur_bound = v;
    bound_writes++;
  endtask

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (pending_squares.size() != 0 &&
          ((requests_taken >= CALM_FIRST && requests_taken < CALM_LAST) ||
           $urandom_range(0, 99) >= STALL_PCT)) begin
        next_square = pending_squares.pop_front();
        in_valid <= 1'b1;
        square_low <= next_square.low;
        square_high <= next_square.high;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // request monitor: predict the root for every accepted square
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) begin
      taken_square.high = square_high;
      taken_square.low = square_low;
      expected_roots.push_back(invert_truncated_square(taken_square, cur_bound));
      requests_taken++;
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_roots.size() == 0) begin
          $error("unexpected result: found %0d root %h", found, root);
          errors++;
        end else begin
          owed = expected_roots.pop_front();
          if (found !== owed.found) begin
            $error("found: expected %0d, actual %0d", owed.found, found);
            errors++;
          end
          if (root !== owed.root) begin
            $error("root: expected %h, actual %h", owed.root, root);
            errors++;
          end
          if (owed.found) roots_found++;
        end
        results_seen++;
      end
      // one long hold-off so the block backs up into its input
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else if (!held_off && results_seen == HOLD_AT) begin
        held_off <= 1'b1;
        hold_left <= HOLD_CYCLES;
        out_ready <= 1'b0;
      end else begin
        out_ready <= (results_seen >= CALM_FIRST && results_seen < CALM_LAST) ||
                     ($urandom_range(0, 99) >= STALL_PCT);
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_MAX) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // stimulus: one phase per bound setting
  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // reset bound: edges of the square range and roots around the bound
    queue_square(3'd0, 64'd0);
    queue_square(3'd7, {SQ_LO_W{1'b1}});   // top of range, ceiling wraps
    queue_square(3'd7, 64'hffff_ffff_ffff_fff8);   // ceiling wraps
    queue_square(3'd7, 64'd0);
    queue_square(3'd0, {SQ_LO_W{1'b1}});
    queue_root({ROOT_W{1'b1}});
    queue_root(BOUND_RESET);
    queue_root(BOUND_RESET - 64'd1);
    queue_root(BOUND_RESET + 64'd1);
    queue_root(64'h8000_0000_0000_0000);
    next_square = truncate_square({ROOT_W{1'b1}});
    queue_square(next_square.high, next_square.low + 64'd1);
    for (int h = 0; h < 8; h++) queue_square(3'(h), rand64());
    for (int i = 0; i < 3; i++) queue_root(BOUND_RESET + (rand64() >> 2));
    queue_random(160);
    wait_drained();

    // no bound: small roots stop being unique
    write_bound('0);
    queue_square(3'd0, 64'd0);
    queue_root(64'd3);
    queue_root(64'h1000_0000_0000_0000);
    queue_root(64'h2000_0000_0000_0000);
    queue_random(140);
    wait_drained();

    // highest bound: only the all-ones root passes
    write_bound({ROOT_W{1'b1}});
    queue_root({ROOT_W{1'b1}});
    queue_root({ROOT_W{1'b1}} - 64'd1);
    queue_random(60);
    wait_drained();

    write_bound(rand64());
    queue_random(140);
    wait_drained();

    write_bound(BOUND_RESET);
    queue_random(150);
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d squares under %0d bound writes plus the reset bound,",
             requests_taken, bound_writes);
    $display("%0d results checked, %0d with a root found, one long receiver hold-off.",
             results_seen, roots_found);
    if (errors == 0 && expected_roots.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== truncated_square_inverter_unit.f =====
rtl/tsi_pkg.sv
rtl/tsi_sqrt.sv
rtl/truncated_square_inverter_unit.sv
verif/tb.sv
